[hdl/mrsp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the Modbus RTU sensor poller.
// No dependencies; used by modbus_rtu_sensor_poller and mrsp_crc.
package mrsp_pkg;

	// Kind of an input beat, carried on s_tuser.
	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_TICK = 1'b1
	} item_kind_t;

	// Configuration register index (paddr[2]).
	localparam logic REG_POLL_INTERVAL = 1'b0;
	localparam logic REG_REGISTER_ADDR = 1'b1;

	localparam logic [15:0] POLL_INTERVAL_RST = 16'd100;
	localparam logic [15:0] REGISTER_ADDR_RST = 16'd256;

	// Parse result codes.
	typedef enum logic [2:0] {
		PS_NONE   = 3'd0,
		PS_OK     = 3'd1,
		PS_SHORT  = 3'd2,
		PS_HEADER = 3'd3,
		PS_ADDR   = 3'd4,
		PS_CRC    = 3'd5
	} parse_status_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_TICK,
		S_READ,
		S_CAPT,
		S_HDR,
		S_RLOAD,
		S_RWAIT,
		S_RCHK,
		S_DIV,
		S_TCLR,
		S_TLOAD,
		S_TWAIT,
		S_SEND
	} seq_state_t;

	// Command to the bit-serial CRC unit.
	typedef struct packed {
		logic       clear;
		logic       load;
		logic [7:0] data;
	} crc_cmd_t;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
	localparam logic [7:0] REPLY_BYTE_COUNT  = 8'h02;
	localparam logic [7:0] QTY_HI            = 8'h00;
	localparam logic [7:0] QTY_LO            = 8'h01;

	localparam int REPLY_LEN = 7;
	localparam int FRAME_LEN = 8;

	// mm / 10 as (mm * 52429) >> 19, exact for any 16-bit mm.
	localparam logic [15:0] DIV10_MUL   = 16'd52429;
	localparam int          DIV10_SHIFT = 19;

endpackage

[hdl/modbus_rtu_sensor_poller.sv]
`timescale 1ns / 1ps
// Modbus RTU master: buffers reply bytes, parses on poll, sends read requests.
// Depends on mrsp_pkg, mrsp_ram, mrsp_crc.
//
// Channel  | Dir | Beat content
// ---------+-----+-------------------------------------------------------------
// s_*      | in  | tuser: kind (0 byte, 1 ms tick); tdata: received byte
// m_*      | out | tdata: request byte + poll info; tlast: final request byte
// APB      | cfg | 0x0 poll_interval_ms, 0x4 register_address (16 bits each)
//
// A received byte is taken in idle. A tick returns to idle when no poll is due.
// A due poll reads the buffer and checks the reply header (not when the buffer is
// empty), then runs the bit-serial CRC over the 5 reply bytes when the header and
// address are good, then over the 6 request bytes (load, 8 shifts, done per byte),
// and sends the request; each request beat advances once it is taken downstream.
// s_tready is low from a tick until the sequencer is back in idle, which with a
// due poll is when the eighth request beat is taken; m_tready low simply holds
// the current beat. Reset clears counters and the sequencer and sets the
// configuration registers to defaults; the receive buffer needs no clearing pass.
// Per-sensor distance/timestamp tables are not kept: only the poll results leave.
module modbus_rtu_sensor_poller #(
	parameter int SENSOR_COUNT    = 4,
	parameter int RX_BUFFER_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] kind
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [7:0] tx_byte, [11:8] polled_address,
	                               // [14:12] parse_status, [17:15] updated_sensor,
	                               // [30:18] dist_cm, [62:31] update_time_ms,
	                               // [63] zero
	output logic        m_tlast,   // last_byte
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(RX_BUFFER_DEPTH);
	localparam int CW = $clog2(RX_BUFFER_DEPTH + 1);

	mrsp_pkg::seq_state_t    state_q, state_d;
	mrsp_pkg::parse_status_t status_q, hdr_status;
	mrsp_pkg::crc_cmd_t      crc_cmd;

	logic [15:0]   interval_q;
	logic [15:0]   regaddr_q;
	logic [31:0]   now_q;
	logic [31:0]   last_q;
	logic [31:0]   elapsed;
	logic [3:0]    pid_q;
	logic [CW-1:0] rx_count_q;
	logic          short_q;
	logic [2:0]    idx_q;
	logic [7:0]    b_q [mrsp_pkg::REPLY_LEN];
	logic [31:0]   prod_q;
	logic [2:0]    sensor_q;
	logic [12:0]   dist_q;
	logic [31:0]   stamp_q;
	logic [15:0]   crc;
	logic          crc_busy;
	logic [7:0]    rdata;
	logic          byte_wr;
	logic          poll_due;
	logic          reply_match;
	logic [7:0]    tx_byte;

	// Request frame byte at position idx.
	function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [3:0] pid,
	                                          input logic [15:0] reg_a, input logic [15:0] c);
		logic [7:0] r;
		case (idx)
			3'd0:    r = {4'b0000, pid};
			3'd1:    r = mrsp_pkg::FUNC_READ_HOLDING;
			3'd2:    r = reg_a[15:8];
			3'd3:    r = reg_a[7:0];
			3'd4:    r = mrsp_pkg::QTY_HI;
			3'd5:    r = mrsp_pkg::QTY_LO;
			3'd6:    r = c[7:0];
			default: r = c[15:8];
		endcase
		return r;
	endfunction

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign prdata = (paddr[2] == mrsp_pkg::REG_REGISTER_ADDR) ? {16'h0000, regaddr_q}
	                                                          : {16'h0000, interval_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= mrsp_pkg::POLL_INTERVAL_RST;
			regaddr_q  <= mrsp_pkg::REGISTER_ADDR_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == mrsp_pkg::REG_POLL_INTERVAL) begin
				interval_q <= pwdata[15:0];
			end else begin
				regaddr_q <= pwdata[15:0];
			end
		end
	end

	// ---------------- receive buffer ----------------
	assign byte_wr = s_tvalid && s_tready && (s_tuser == mrsp_pkg::KIND_BYTE)
	                 && (rx_count_q < CW'(RX_BUFFER_DEPTH));

	mrsp_ram #(
		.WIDTH(8),
		.DEPTH(RX_BUFFER_DEPTH)
	) u_rx_buf (
		.clk  (clk),
		.we   (byte_wr),
		.waddr(rx_count_q[AW-1:0]),
		.wdata(s_tdata),
		.raddr(AW'(idx_q)),
		.rdata(rdata)
	);

	// ---------------- shared CRC unit ----------------
	mrsp_crc u_crc (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (crc_cmd),
		.crc   (crc),
		.busy  (crc_busy)
	);

	// ---------------- decode helpers ----------------
	assign elapsed     = now_q - last_q;
	assign poll_due    = !(elapsed < {16'h0000, interval_q});
	assign reply_match = (crc == {b_q[6], b_q[5]});

	always_comb begin
		if (short_q) begin
			hdr_status = mrsp_pkg::PS_SHORT;
		end else if (b_q[1] != mrsp_pkg::FUNC_READ_HOLDING
		             || b_q[2] != mrsp_pkg::REPLY_BYTE_COUNT) begin
			hdr_status = mrsp_pkg::PS_HEADER;
		end else if (b_q[0] == 8'h00 || b_q[0] > 8'(SENSOR_COUNT)) begin
			hdr_status = mrsp_pkg::PS_ADDR;
		end else begin
			hdr_status = mrsp_pkg::PS_OK;   // provisional until the CRC check
		end
	end

	// ---------------- sequencer: next state and unit commands ----------------
	always_comb begin
		state_d = state_q;
		crc_cmd = '0;
		case (state_q)
			mrsp_pkg::S_IDLE: begin
				if (s_tvalid && s_tuser == mrsp_pkg::KIND_TICK) begin
					state_d = mrsp_pkg::S_TICK;
				end
			end
			mrsp_pkg::S_TICK: begin
				if (!poll_due) begin
					state_d = mrsp_pkg::S_IDLE;
				end else if (rx_count_q != '0) begin
					state_d = mrsp_pkg::S_READ;
				end else begin
					state_d = mrsp_pkg::S_TCLR;
				end
			end
			mrsp_pkg::S_READ: begin
				state_d = mrsp_pkg::S_CAPT;
			end
			mrsp_pkg::S_CAPT: begin
				state_d = (idx_q == 3'(mrsp_pkg::REPLY_LEN - 1)) ? mrsp_pkg::S_HDR
				                                                 : mrsp_pkg::S_READ;
			end
			mrsp_pkg::S_HDR: begin
				if (hdr_status == mrsp_pkg::PS_OK) begin
					crc_cmd.clear = 1'b1;
					state_d = mrsp_pkg::S_RLOAD;
				end else begin
					state_d = mrsp_pkg::S_TCLR;
				end
			end
			mrsp_pkg::S_RLOAD: begin
				crc_cmd.load = 1'b1;
				crc_cmd.data = b_q[idx_q];
				state_d = mrsp_pkg::S_RWAIT;
			end
			mrsp_pkg::S_RWAIT: begin
				if (!crc_busy) begin
					state_d = (idx_q == 3'd4) ? mrsp_pkg::S_RCHK : mrsp_pkg::S_RLOAD;
				end
			end
			mrsp_pkg::S_RCHK: begin
				state_d = reply_match ? mrsp_pkg::S_DIV : mrsp_pkg::S_TCLR;
			end
			mrsp_pkg::S_DIV: begin
				state_d = mrsp_pkg::S_TCLR;
			end
			mrsp_pkg::S_TCLR: begin
				crc_cmd.clear = 1'b1;
				state_d = mrsp_pkg::S_TLOAD;
			end
			mrsp_pkg::S_TLOAD: begin
				crc_cmd.load = 1'b1;
				crc_cmd.data = frame_byte(idx_q, pid_q, regaddr_q, crc);
				state_d = mrsp_pkg::S_TWAIT;
			end
			mrsp_pkg::S_TWAIT: begin
				if (!crc_busy) begin
					state_d = (idx_q == 3'd5) ? mrsp_pkg::S_SEND : mrsp_pkg::S_TLOAD;
				end
			end
			mrsp_pkg::S_SEND: begin
				if (m_tready && idx_q == 3'(mrsp_pkg::FRAME_LEN - 1)) begin
					state_d = mrsp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mrsp_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrsp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- control counters ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q      <= '0;
			last_q     <= '0;
			pid_q      <= '0;
			rx_count_q <= '0;
			idx_q      <= '0;
			status_q   <= mrsp_pkg::PS_NONE;
		end else begin
			if (byte_wr) begin
				rx_count_q <= rx_count_q + CW'(1);
			end
			case (state_q)
				mrsp_pkg::S_IDLE: begin
					if (s_tvalid && s_tuser == mrsp_pkg::KIND_TICK) begin
						now_q <= now_q + 32'd1;
					end
				end
				mrsp_pkg::S_TICK: begin
					idx_q <= '0;
					if (poll_due) begin
						last_q     <= now_q;
						rx_count_q <= '0;
						status_q   <= mrsp_pkg::PS_NONE;
						pid_q      <= (pid_q >= 4'(SENSOR_COUNT)) ? 4'd1 : pid_q + 4'd1;
					end
				end
				mrsp_pkg::S_CAPT: begin
					idx_q <= (idx_q == 3'(mrsp_pkg::REPLY_LEN - 1)) ? 3'd0 : idx_q + 3'd1;
				end
				mrsp_pkg::S_HDR: begin
					status_q <= hdr_status;
				end
				mrsp_pkg::S_RWAIT: begin
					if (!crc_busy && idx_q != 3'd4) begin
						idx_q <= idx_q + 3'd1;
					end
				end
				mrsp_pkg::S_RCHK: begin
					if (!reply_match) begin
						status_q <= mrsp_pkg::PS_CRC;
					end
				end
				mrsp_pkg::S_TCLR: begin
					idx_q <= '0;
				end
				mrsp_pkg::S_TWAIT: begin
					if (!crc_busy) begin
						idx_q <= (idx_q == 3'd5) ? 3'd0 : idx_q + 3'd1;
					end
				end
				mrsp_pkg::S_SEND: begin
					if (m_tready) begin
						idx_q <= idx_q + 3'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- payload registers ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			mrsp_pkg::S_TICK: begin
				short_q  <= (rx_count_q < CW'(mrsp_pkg::REPLY_LEN));
				sensor_q <= '0;
				dist_q   <= '0;
				stamp_q  <= '0;
			end
			mrsp_pkg::S_CAPT: begin
				b_q[idx_q] <= rdata;
			end
			mrsp_pkg::S_RCHK: begin
				prod_q <= {b_q[3], b_q[4]} * mrsp_pkg::DIV10_MUL;
			end
			mrsp_pkg::S_DIV: begin
				dist_q   <= prod_q[mrsp_pkg::DIV10_SHIFT +: 13];
				sensor_q <= 3'(b_q[0] - 8'd1);
				stamp_q  <= now_q;
			end
			default: begin
			end
		endcase
	end

	// ---------------- handshakes and output beat ----------------
	assign s_tready = (state_q == mrsp_pkg::S_IDLE);
	assign m_tvalid = (state_q == mrsp_pkg::S_SEND);
	assign m_tlast  = (idx_q == 3'(mrsp_pkg::FRAME_LEN - 1));
	assign tx_byte  = frame_byte(idx_q, pid_q, regaddr_q, crc);
	assign m_tdata  = {1'b0, stamp_q, dist_q, sensor_q, status_q, pid_q, tx_byte};

	// ---------------- assertions ----------------
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while a request beat is pending");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready)
		else $error("sequencer did not return to idle after the final beat");

	a_crc_free: assert property (@(posedge clk) disable iff (!arst_n)
		crc_cmd.load |-> !crc_busy)
		else $error("CRC unit loaded while still shifting");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_q == mrsp_pkg::PS_OK |-> dist_q <= 13'd6553)
		else $error("distance out of range");

	a_rx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= CW'(RX_BUFFER_DEPTH))
		else $error("receive count beyond buffer depth");

endmodule

[hdl/mrsp_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/mrsp_crc.sv]
`timescale 1ns / 1ps
// Bit-serial CRC16-Modbus unit: one polynomial step per cycle, 8 per byte.
// Depends on mrsp_pkg.
module mrsp_crc (
	input  logic              clk,
	input  logic              arst_n,
	input  mrsp_pkg::crc_cmd_t cmd,
	output logic [15:0]       crc,
	output logic              busy
);

	logic [15:0] crc_q;
	logic [3:0]  cnt_q;

	assign crc  = crc_q;
	assign busy = (cnt_q != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= mrsp_pkg::CRC_INIT;
			cnt_q <= 4'd0;
		end else if (cmd.clear) begin
			crc_q <= mrsp_pkg::CRC_INIT;
			cnt_q <= 4'd0;
		end else if (cmd.load) begin
			crc_q <= crc_q ^ {8'h00, cmd.data};
			cnt_q <= 4'd8;
		end else if (busy) begin
			// reflected shift, poly applied when the dropped bit is set
			crc_q <= crc_q[0] ? ((crc_q >> 1) ^ mrsp_pkg::CRC_POLY) : (crc_q >> 1);
			cnt_q <= cnt_q - 4'd1;
		end
	end

endmodule
